// ===== src/sbt_pkg.sv =====
`timescale 1ns / 1ps
package sbt_pkg;
   localparam int POSITION_BITS_DEF = 24;

   localparam logic [2:0] M_IDLE    = 3'd0;
   localparam logic [2:0] M_NUMBER  = 3'd1;
   localparam logic [2:0] M_IDENT   = 3'd2;
   localparam logic [2:0] M_SLASH   = 3'd3;
   localparam logic [2:0] M_COMMENT = 3'd4;
   localparam logic [2:0] M_BAD     = 3'd5;

   localparam logic [4:0] K_HASH     = 5'd12;
   localparam logic [4:0] K_IDENT    = 5'd13;
   localparam logic [4:0] K_NUMBER   = 5'd14;
   localparam logic [4:0] K_MESSAGES = 5'd15;
   localparam logic [4:0] K_STRUCT   = 5'd16;
   localparam logic [4:0] K_VERSION  = 5'd17;
   localparam logic [4:0] K_CONST    = 5'd18;
   localparam logic [4:0] K_TYPE     = 5'd19;
   localparam logic [4:0] K_EOF      = 5'd20;
   localparam logic [4:0] K_BAD      = 5'd21;
   localparam logic [4:0] K_OVERFLOW = 5'd22;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_END  = 1'b1;

   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_UNDER = 8'h5F;

   localparam logic [63:0] KW_MESSAGES = 64'h6D65737361676573;
   localparam logic [63:0] KW_STRUCT   = 64'h0000737472756374;
   localparam logic [63:0] KW_VERSION  = 64'h0076657273696F6E;
   localparam logic [63:0] KW_CONST    = 64'h000000636F6E7374;
   localparam logic [63:0] KW_TYPE     = 64'h0000000074797065;

   // punctuation index, 4'hF when none
   function automatic logic [3:0] punct_index(input logic [7:0] c);
      logic [3:0] r;
      r = 4'hF;
      case (c)
         8'h28: r = 4'd0;
         8'h29: r = 4'd1;
         8'h7B: r = 4'd2;
         8'h7D: r = 4'd3;
         8'h5B: r = 4'd4;
         8'h5D: r = 4'd5;
         8'h2C: r = 4'd6;
         8'h3B: r = 4'd7;
         8'h26: r = 4'd8;
         8'h5E: r = 4'd9;
         8'h3A: r = 4'd10;
         8'h3D: r = 4'd11;
         default: r = 4'hF;
      endcase
      return r;
   endfunction

   function automatic logic dec_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_bad(input logic [7:0] c);
      return (punct_index(c) == 4'hF) && !dec_digit(c) && !is_alpha(c) &&
             !(c == 8'h23 || c == CH_SLASH || c == 8'h20 || c == 8'h09 ||
               c == CH_LF || c == 8'h0D);
   endfunction

   typedef struct packed {
      logic [4:0]  kind;
      logic [63:0] value;
      logic [31:0] length;
      logic [31:0] line;
      logic [31:0] column;
      logic [31:0] offset;
   } tok_type;

   typedef struct packed {
      logic [1:0] count;
      tok_type    t0;
      tok_type    t1;
      tok_type    t2;
   } batch_type;
endpackage

// ===== src/sbt_req_if.sv =====
`timescale 1ns / 1ps
interface sbt_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] byte_req;
   modport source (output valid, output op, output byte_req, input ready);
   modport sink (input valid, input op, input byte_req, output ready);
endinterface

// ===== src/sbt_rsp_if.sv =====
`timescale 1ns / 1ps
interface sbt_rsp_if #(parameter int PosBits = 24);
   logic               valid;
   logic               ready;
   logic [4:0]         kind;
   logic [63:0]        value;
   logic [PosBits-1:0] length;
   logic [PosBits-1:0] line;
   logic [PosBits-1:0] column;
   logic [PosBits-1:0] offset;
   logic               last;
   modport source (output valid, output kind, output value, output length, output line,
                   output column, output offset, output last, input ready);
   modport sink (input valid, input kind, input value, input length, input line,
                 input column, input offset, input last, output ready);
endinterface

// ===== src/sbt_scan.sv =====
`timescale 1ns / 1ps
module sbt_scan #(
   parameter int PosBits = sbt_pkg::POSITION_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  op,
   input  logic [7:0]            c,
   output sbt_pkg::batch_type    batch
);
   localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};
   localparam logic [PosBits-1:0] PosOne = {{(PosBits-1){1'b0}}, 1'b1};

   logic [2:0]         mode_ff, mode_in;
   logic [63:0]        num_ff, num_in;
   logic               ovf_ff, ovf_in;
   logic [63:0]        pre_ff, pre_in;
   logic [PosBits-1:0] plen_ff, plen_in, pline_ff, pline_in, pcol_ff, pcol_in;
   logic [PosBits-1:0] poff_ff, poff_in, cline_ff, cline_in, ccol_ff, ccol_in;
   logic [PosBits-1:0] coff_ff, coff_in;

   function automatic logic [PosBits-1:0] sat_inc(input logic [PosBits-1:0] v);
      return (v == PosMax) ? v : v + PosOne;
   endfunction

   function automatic logic [31:0] wide(input logic [PosBits-1:0] v);
      return 32'(v);
   endfunction

   logic [67:0]  num_x10;
   logic [67:0]  num_next;
   logic [3:0]   pidx;
   logic         taken;
   logic [4:0]   id_kind;
   sbt_pkg::tok_type q [3];
   sbt_pkg::tok_type pend;
   logic [1:0]   n;

   always_comb begin
      num_x10  = ({4'd0, num_ff} << 3) + ({4'd0, num_ff} << 1);
      num_next = num_x10 + 68'(c - 8'h30);
      pidx     = sbt_pkg::punct_index(c);
      id_kind  = sbt_pkg::K_IDENT;
      if (plen_ff == PosBits'(8) && pre_ff == sbt_pkg::KW_MESSAGES)
         id_kind = sbt_pkg::K_MESSAGES;
      if (plen_ff == PosBits'(6) && pre_ff == sbt_pkg::KW_STRUCT)
         id_kind = sbt_pkg::K_STRUCT;
      if (plen_ff == PosBits'(7) && pre_ff == sbt_pkg::KW_VERSION)
         id_kind = sbt_pkg::K_VERSION;
      if (plen_ff == PosBits'(5) && pre_ff == sbt_pkg::KW_CONST)
         id_kind = sbt_pkg::K_CONST;
      if (plen_ff == PosBits'(4) && pre_ff == sbt_pkg::KW_TYPE)
         id_kind = sbt_pkg::K_TYPE;

      pend.kind   = sbt_pkg::K_BAD;
      pend.value  = '0;
      pend.length = wide(plen_ff);
      pend.line   = wide(pline_ff);
      pend.column = wide(pcol_ff);
      pend.offset = wide(poff_ff);
      for (int i = 0; i < 3; i++) q[i] = pend;

      mode_in = mode_ff; num_in = num_ff; ovf_in = ovf_ff; pre_in = pre_ff;
      plen_in = plen_ff; pline_in = pline_ff; pcol_in = pcol_ff; poff_in = poff_ff;
      cline_in = cline_ff; ccol_in = ccol_ff; coff_in = coff_ff;
      n = 2'd0;
      taken = 1'b0;

      if (op == sbt_pkg::OP_BYTE) begin
         unique case (mode_ff)
            sbt_pkg::M_NUMBER: if (sbt_pkg::dec_digit(c)) begin
               taken = 1'b1;
               if (num_next[67:64] != 4'd0) ovf_in = 1'b1;
               num_in = num_next[63:0];
               plen_in = sat_inc(plen_ff);
            end
            sbt_pkg::M_IDENT: if (sbt_pkg::is_alpha(c) || sbt_pkg::dec_digit(c) ||
                                  c == sbt_pkg::CH_UNDER) begin
               taken = 1'b1;
               if (plen_ff < PosBits'(8)) pre_in = {pre_ff[55:0], c};
               plen_in = sat_inc(plen_ff);
            end
            sbt_pkg::M_BAD: if (sbt_pkg::is_bad(c)) begin
               taken = 1'b1;
               plen_in = sat_inc(plen_ff);
            end
            sbt_pkg::M_SLASH: begin
               mode_in = sbt_pkg::M_IDLE;
               if (c == sbt_pkg::CH_SLASH) begin
                  mode_in = sbt_pkg::M_COMMENT;
                  taken = 1'b1;
               end
            end
            sbt_pkg::M_COMMENT: begin
               if (c != sbt_pkg::CH_LF) taken = 1'b1;
               else mode_in = sbt_pkg::M_IDLE;
            end
            default: mode_in = sbt_pkg::M_IDLE;
         endcase
      end

      if (op == sbt_pkg::OP_END || !taken) begin
         // flush pending token
         if (mode_ff == sbt_pkg::M_NUMBER) begin
            if (ovf_ff) begin
               q[0].kind = sbt_pkg::K_OVERFLOW;
               q[1].kind = sbt_pkg::K_NUMBER;
               q[1].value = num_ff;
               n = 2'd2;
            end else begin
               q[0].kind = sbt_pkg::K_NUMBER;
               q[0].value = num_ff;
               n = 2'd1;
            end
         end else if (mode_ff == sbt_pkg::M_IDENT) begin
            q[0].kind = id_kind;
            n = 2'd1;
         end else if (mode_ff == sbt_pkg::M_BAD) begin
            n = 2'd1;
         end
         if (mode_ff != sbt_pkg::M_SLASH && mode_ff != sbt_pkg::M_COMMENT)
            mode_in = sbt_pkg::M_IDLE;
         if (op == sbt_pkg::OP_BYTE && mode_ff != sbt_pkg::M_COMMENT)
            mode_in = sbt_pkg::M_IDLE;
      end

      if (op == sbt_pkg::OP_END) begin
         q[n].kind = sbt_pkg::K_EOF;
         q[n].value = '0;
         q[n].length = '0;
         q[n].line = wide(cline_ff);
         q[n].column = wide(ccol_ff);
         q[n].offset = wide(coff_ff);
         n = n + 2'd1;
         mode_in = sbt_pkg::M_IDLE; num_in = '0; ovf_in = 1'b0; pre_in = '0;
         plen_in = '0; pline_in = PosOne; pcol_in = '0; poff_in = '0;
         cline_in = PosOne; ccol_in = '0; coff_in = '0;
      end else begin
         if (!taken) begin
            if (pidx != 4'hF || c == 8'h23) begin
               q[n].kind = (pidx != 4'hF) ? {1'b0, pidx} : sbt_pkg::K_HASH;
               q[n].value = '0;
               q[n].length = 32'd1;
               q[n].line = wide(cline_ff);
               q[n].column = wide(ccol_ff);
               q[n].offset = wide(coff_ff);
               n = n + 2'd1;
            end else if (c == sbt_pkg::CH_SLASH) begin
               mode_in = sbt_pkg::M_SLASH;
            end else if (sbt_pkg::dec_digit(c) || sbt_pkg::is_alpha(c) ||
                         sbt_pkg::is_bad(c)) begin
               mode_in = sbt_pkg::dec_digit(c) ? sbt_pkg::M_NUMBER :
                         sbt_pkg::is_alpha(c) ? sbt_pkg::M_IDENT : sbt_pkg::M_BAD;
               plen_in = PosOne; pline_in = cline_ff; pcol_in = ccol_ff; poff_in = coff_ff;
               if (sbt_pkg::dec_digit(c)) begin
                  num_in = 64'(c - 8'h30);
                  ovf_in = 1'b0;
               end
               if (sbt_pkg::is_alpha(c)) pre_in = 64'(c);
            end
         end
         coff_in = sat_inc(coff_ff);
         if (c == sbt_pkg::CH_LF) begin
            cline_in = sat_inc(cline_ff);
            ccol_in = '0;
         end else begin
            ccol_in = sat_inc(ccol_ff);
         end
      end

      batch.count = n;
      batch.t0 = q[0];
      batch.t1 = q[1];
      batch.t2 = q[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= sbt_pkg::M_IDLE; num_ff <= '0; ovf_ff <= 1'b0; pre_ff <= '0;
         plen_ff <= '0; pline_ff <= PosOne; pcol_ff <= '0; poff_ff <= '0;
         cline_ff <= PosOne; ccol_ff <= '0; coff_ff <= '0;
      end else if (step) begin
         mode_ff <= mode_in; num_ff <= num_in; ovf_ff <= ovf_in; pre_ff <= pre_in;
         plen_ff <= plen_in; pline_ff <= pline_in; pcol_ff <= pcol_in; poff_ff <= poff_in;
         cline_ff <= cline_in; ccol_ff <= ccol_in; coff_ff <= coff_in;
      end
   end

   a_mode_legal: assert property (@(posedge clock) disable iff (reset)
      mode_ff <= sbt_pkg::M_BAD) else $error("scan mode out of range");
   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      cline_ff != '0) else $error("cursor line zero");
   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      step && op == sbt_pkg::OP_END |=> mode_ff == sbt_pkg::M_IDLE && coff_ff == '0)
      else $error("end beat did not restart source");
   a_end_emits: assert property (@(posedge clock) disable iff (reset)
      op == sbt_pkg::OP_END |-> batch.count != 2'd0) else $error("end beat without eof");
endmodule

// ===== src/sbt_out_queue.sv =====
`timescale 1ns / 1ps
module sbt_out_queue #(
   parameter int PosBits = sbt_pkg::POSITION_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  sbt_pkg::batch_type batch,
   output logic               can_load,
   sbt_rsp_if.source          rsp
);
   sbt_pkg::tok_type  tok_ff [3];
   logic [1:0]        cnt_ff;
   logic [1:0]        pos_ff;
   logic              pop;
   sbt_pkg::tok_type  cur;

   assign pop      = rsp.valid && rsp.ready;
   assign can_load = (cnt_ff == 2'd0) || (pop && (pos_ff + 2'd1 == cnt_ff));
   assign cur      = tok_ff[pos_ff];

   assign rsp.valid  = cnt_ff != 2'd0;
   assign rsp.kind   = cur.kind;
   assign rsp.value  = cur.value;
   assign rsp.length = cur.length[PosBits-1:0];
   assign rsp.line   = cur.line[PosBits-1:0];
   assign rsp.column = cur.column[PosBits-1:0];
   assign rsp.offset = cur.offset[PosBits-1:0];
   assign rsp.last   = pos_ff + 2'd1 == cnt_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         tok_ff[0] <= batch.t0;
         tok_ff[1] <= batch.t1;
         tok_ff[2] <= batch.t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         pos_ff <= 2'd0;
      end else if (load) begin
         cnt_ff <= batch.count;
         pos_ff <= 2'd0;
      end else if (pop) begin
         if (rsp.last) begin
            cnt_ff <= 2'd0;
            pos_ff <= 2'd0;
         end else begin
            pos_ff <= pos_ff + 2'd1;
         end
      end
   end

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd0 |-> pos_ff < cnt_ff) else $error("read pointer past fill");
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> can_load) else $error("load over undelivered beats");
   a_drain: assert property (@(posedge clock) disable iff (reset)
      pop && rsp.last && !load |=> cnt_ff == 2'd0) else $error("queue not drained");
endmodule

// ===== src/schema_byte_tokenizer_core.sv =====
`timescale 1ns / 1ps
// Output: the first result of a beat appears on rsp the cycle after it is accepted.
// Throughput: one input beat per cycle while each yields at most one result and rsp
// is ready; a beat with more results holds off req until they drain from the queue.
// Reset: synchronous, clears scanner state to a fresh source and empties the queue.
module schema_byte_tokenizer_core #(
   parameter int POSITION_BITS = sbt_pkg::POSITION_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   sbt_req_if.sink   req,
   sbt_rsp_if.source rsp
);
   sbt_pkg::batch_type batch;
   logic               can_load;
   logic               step;

   assign req.ready = can_load;
   assign step      = req.valid && can_load;

   sbt_scan #(.PosBits(POSITION_BITS)) u_scan (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .op    (req.op),
      .c     (req.byte_req),
      .batch (batch)
   );

   sbt_out_queue #(.PosBits(POSITION_BITS)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .load     (step),
      .batch    (batch),
      .can_load (can_load),
      .rsp      (rsp)
   );
endmodule
